### src/xcfr_pkg.sv
// Package for the XOR-checked frame receiver.
// Holds the parser phase type, the result record and the register indexes.
// No dependencies; every other file of the block imports it.
package xcfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int SESSION_W = 48;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RX_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_START = 1'd1;

    // Reset values of the start byte registers.
    localparam logic [BYTE_W-1:0] RX_START_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] TX_START_RESET = 8'd85;

    // Start kind codes.
    localparam logic KIND_RX = 1'b0;
    localparam logic KIND_TX = 1'b1;

    // Check status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_CMD,
        PH_SESS,
        PH_PAY,
        PH_SUM
    } t_phase;

    typedef struct packed {
        logic                 start_kind;
        logic [BYTE_W-1:0]    command;
        logic [SESSION_W-1:0] session_value;
        logic [BYTE_W-1:0]    payload_byte;
        logic [BYTE_W-1:0]    payload_index;
        logic                 is_last;
        logic                 status;
        logic [BYTE_W-1:0]    sum_residue;
    } t_result;

endpackage

### src/xcfr_parser.sv
// Frame parser of the XOR-checked frame receiver: phase machine, counters,
// running XOR and held header fields. Produces at most one result per byte.
// Depends on xcfr_pkg.
module xcfr_parser #(
    parameter int SESSION_BYTES = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [xcfr_pkg::BYTE_W-1:0] i_byte,
    input  logic [xcfr_pkg::BYTE_W-1:0] i_rx_start,
    input  logic [xcfr_pkg::BYTE_W-1:0] i_tx_start,
    output logic                      o_res_valid,
    output xcfr_pkg::t_result         o_res
);
    import xcfr_pkg::*;

    localparam logic [BYTE_W-1:0] SESS_CNT = BYTE_W'(SESSION_BYTES);
    localparam logic [BYTE_W-1:0] MIN_LEN  = BYTE_W'(SESSION_BYTES + 2);

    t_phase               r_phase, n_phase;
    logic [BYTE_W-1:0]    r_length, n_length;
    logic [BYTE_W-1:0]    r_pos, n_pos;
    logic [BYTE_W-1:0]    r_xor, n_xor;
    logic [BYTE_W-1:0]    r_command, n_command;
    logic [SESSION_W-1:0] r_session, n_session;
    logic                 r_kind, n_kind;

    logic [BYTE_W-1:0]    pay_count;
    logic [BYTE_W-1:0]    pos_inc;
    logic [BYTE_W-1:0]    residue;

    assign pay_count = r_length - MIN_LEN;
    assign pos_inc   = r_pos + BYTE_W'(1);
    assign residue   = r_xor ^ i_byte;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_fire) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == i_rx_start || i_byte == i_tx_start) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_phase = (i_byte < MIN_LEN) ? PH_HUNT : PH_CMD;
                end
                PH_CMD: begin
                    n_phase = PH_SESS;
                end
                PH_SESS: begin
                    if (pos_inc >= SESS_CNT) begin
                        n_phase = (pay_count == '0) ? PH_SUM : PH_PAY;
                    end
                end
                PH_PAY: begin
                    if (pos_inc >= pay_count) begin
                        n_phase = PH_SUM;
                    end
                end
                PH_SUM: begin
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // Datapath updates and the result record.
    always_comb begin
        n_length  = r_length;
        n_pos     = r_pos;
        n_xor     = r_xor;
        n_command = r_command;
        n_session = r_session;
        n_kind    = r_kind;

        o_res_valid         = 1'b0;
        o_res.start_kind    = r_kind;
        o_res.command       = r_command;
        o_res.session_value = r_session;
        o_res.payload_byte  = i_byte;
        o_res.payload_index = r_pos;
        o_res.is_last       = 1'b0;
        o_res.status        = STATUS_OK;
        o_res.sum_residue   = '0;

        if (i_fire) begin
            case (r_phase)
                PH_HUNT: begin
                    // The first start byte wins when both registers match.
                    if (i_byte == i_rx_start) begin
                        n_kind = KIND_RX;
                    end else if (i_byte == i_tx_start) begin
                        n_kind = KIND_TX;
                    end
                end
                PH_LEN: begin
                    if (i_byte >= MIN_LEN) begin
                        n_length  = i_byte;
                        n_xor     = i_byte;
                        n_session = '0;
                        n_pos     = '0;
                    end
                end
                PH_CMD: begin
                    n_command = i_byte;
                    n_xor     = residue;
                    n_pos     = '0;
                end
                PH_SESS: begin
                    n_session = {r_session[SESSION_W-BYTE_W-1:0], i_byte};
                    n_xor     = residue;
                    n_pos     = (pos_inc >= SESS_CNT) ? '0 : pos_inc;
                end
                PH_PAY: begin
                    n_xor       = residue;
                    n_pos       = pos_inc;
                    o_res_valid = 1'b1;
                end
                PH_SUM: begin
                    n_xor               = residue;
                    n_pos               = '0;
                    o_res_valid         = 1'b1;
                    o_res.payload_byte  = '0;
                    o_res.payload_index = pay_count;
                    o_res.is_last       = 1'b1;
                    o_res.status        = (residue != '0) ? STATUS_BAD : STATUS_OK;
                    o_res.sum_residue   = residue;
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_length  <= '0;
            r_pos     <= '0;
            r_xor     <= '0;
            r_command <= '0;
            r_session <= '0;
            r_kind    <= KIND_RX;
        end else begin
            r_phase   <= n_phase;
            r_length  <= n_length;
            r_pos     <= n_pos;
            r_xor     <= n_xor;
            r_command <= n_command;
            r_session <= n_session;
            r_kind    <= n_kind;
        end
    end

endmodule

### src/xor_checked_frame_receiver.sv
// XOR-checked frame receiver. Takes one serial byte per transfer and accepts a
// new byte in every cycle unless o_stall is high. Each byte is captured in an
// input register, parsed in one step of the frame phase machine, and any result
// lands in an output register, from which it is offered on the result channel.
// A frame is a start byte (either configured value), a length L, a command,
// SESSION_BYTES session bytes, L - SESSION_BYTES - 2 payload bytes and a sum
// byte; lengths below SESSION_BYTES + 2 drop the frame. Every payload byte
// gives one result with its index, and the sum byte gives a last result with
// the XOR residue and an error flag. Start bytes should be written while no
// frame is in progress. Depends on xcfr_pkg and xcfr_parser.
module xor_checked_frame_receiver #(
    parameter int SESSION_BYTES = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [xcfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [xcfr_pkg::BYTE_W-1:0]   i_cfg_data,
    // Byte input channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [xcfr_pkg::BYTE_W-1:0]   i_rx_byte,
    // Result channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_start_kind,
    output logic [xcfr_pkg::BYTE_W-1:0]   o_command,
    output logic [xcfr_pkg::SESSION_W-1:0] o_session_value,
    output logic [xcfr_pkg::BYTE_W-1:0]   o_payload_byte,
    output logic [xcfr_pkg::BYTE_W-1:0]   o_payload_index,
    output logic                          o_is_last,
    output logic                          o_status,
    output logic [xcfr_pkg::BYTE_W-1:0]   o_sum_residue
);
    import xcfr_pkg::*;

    logic [BYTE_W-1:0] r_rx_start;
    logic [BYTE_W-1:0] r_tx_start;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic    advance;
    logic    fire;
    logic    res_valid;
    t_result res;

    // The parse step runs when the output register is free or being drained.
    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    // Start byte registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_start <= RX_START_RESET;
            r_tx_start <= TX_START_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RX_START: r_rx_start <= i_cfg_data;
                CFG_TX_START: r_tx_start <= i_cfg_data;
                default: begin
                    r_rx_start <= r_rx_start;
                end
            endcase
        end
    end

    // Input register: captures a byte on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    xcfr_parser #(
        .SESSION_BYTES (SESSION_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_rx_start  (r_rx_start),
        .i_tx_start  (r_tx_start),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_start_kind    = r_out.start_kind;
    assign o_command       = r_out.command;
    assign o_session_value = r_out.session_value;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_index = r_out.payload_index;
    assign o_is_last       = r_out.is_last;
    assign o_status        = r_out.status;
    assign o_sum_residue   = r_out.sum_residue;

endmodule

### src/xcfr_checker.sv
// Port-level checks for the XOR-checked frame receiver, and the bind that
// attaches them to the top level. Depends on xcfr_pkg.
module xcfr_checker #(
    parameter int SESSION_BYTES = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_stall,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic                          o_start_kind,
    input  logic [xcfr_pkg::BYTE_W-1:0]   o_command,
    input  logic [xcfr_pkg::SESSION_W-1:0] o_session_value,
    input  logic [xcfr_pkg::BYTE_W-1:0]   o_payload_byte,
    input  logic [xcfr_pkg::BYTE_W-1:0]   o_payload_index,
    input  logic                          o_is_last,
    input  logic                          o_status,
    input  logic [xcfr_pkg::BYTE_W-1:0]   o_sum_residue
);
    import xcfr_pkg::*;

    localparam logic [BYTE_W-1:0] MAX_PAY_IDX = BYTE_W'(255 - SESSION_BYTES - 3);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_payload_byte)
            && $stable(o_payload_index) && $stable(o_is_last)
            && $stable(o_sum_residue) && $stable(o_session_value)
            && $stable(o_start_kind) && $stable(o_command) && $stable(o_status))
        else $error("stalled result changed");

    // The input is only held off while a result waits on a stalled receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    // Payload results carry no check status.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_last |-> o_status == STATUS_OK && o_sum_residue == '0)
        else $error("payload result carries check status");

    // The error flag follows the residue on the last result.
    a_status_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_last |-> o_status == (o_sum_residue != '0))
        else $error("status disagrees with residue");

    // A payload index stays inside the longest possible payload.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_last |-> o_payload_index <= MAX_PAY_IDX)
        else $error("payload index out of range");

endmodule

bind xor_checked_frame_receiver xcfr_checker #(
    .SESSION_BYTES (SESSION_BYTES)
) u_xcfr_checker (.*);
